@@ hw/rtl/kmscd_pkg.sv @@
// Shared types and constants of the key matrix scanner with change detection.
package kmscd_pkg;

    localparam int MIN_LINES         = 2;
    localparam int MAX_LINES         = 16;
    localparam int DRIVE_LINES_DEF   = 16;
    localparam int SENSE_LINES_DEF   = 16;

    localparam int ROW_W             = 4;
    localparam int BITS_W            = 16;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 32;
    localparam int M_TUSER_W         = 1;

    localparam int SCANNED_ROW_LSB   = 0;
    localparam int SENSE_INDEX_LSB   = 4;
    localparam int CONNECTED_BIT     = 8;
    localparam int ROW_BITS_LSB      = 9;
    localparam int NEXT_ROW_LSB      = 25;
    localparam int SCAN_DONE_BIT     = 29;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    function automatic int clamp_lines(input int n);
        if (n < MIN_LINES) begin
            return MIN_LINES;
        end else if (n > MAX_LINES) begin
            return MAX_LINES;
        end else begin
            return n;
        end
    endfunction

endpackage

@@ hw/rtl/kmscd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module kmscd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/key_matrix_scan_change_detect.sv @@
// Top level of the key matrix scanner with change detection.
//
// Each input transaction carries the sense levels sampled while the current drive line
// was held low; the contact image of every row lives in a small RAM with a registered
// read. An item goes through the RAM read, then compare and write back, then one
// emission step for each result it causes: a single status or dump result, or up to
// sixteen when all sixteen contacts of a row change; the results of an item leave
// through an output register, one per cycle while the consumer keeps m_tready high.
// Row valid bits cleared by reset make the image read as all zeros, so no clearing
// pass is needed. After the single dump pass every further item is accepted and
// dropped without a result until reset.
module key_matrix_scan_change_detect #(
    parameter int DRIVE_LINES = kmscd_pkg::DRIVE_LINES_DEF,
    parameter int SENSE_LINES = kmscd_pkg::SENSE_LINES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: cfg_data is dump_mode.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    // s_tdata: sense_bits[15:0].
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kmscd_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: scanned_row[3:0], sense_index[7:4], connected[8], row_bits[24:9],
    // next_drive_row[28:25], scan_done[29], zero padding[31:30].
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kmscd_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: change_valid[0].
    output logic [kmscd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                             m_tlast
);

    localparam int ROWS = kmscd_pkg::clamp_lines(DRIVE_LINES);
    localparam int COLS = kmscd_pkg::clamp_lines(SENSE_LINES);
    localparam int AW   = $clog2(ROWS);
    localparam logic [kmscd_pkg::BITS_W-1:0] SENSE_MASK =
        kmscd_pkg::BITS_W'((17'd1 << COLS) - 17'd1);

    kmscd_pkg::state_t state_reg, state_next;

    logic                            dump_mode_reg;
    logic                            first_pass_reg, first_pass_next;
    logic                            dump_finished_reg, dump_finished_next;
    logic [kmscd_pkg::ROW_W-1:0]     drive_row_reg, drive_row_next;
    logic [ROWS-1:0]                 row_valid_reg, row_valid_next;

    logic [kmscd_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [kmscd_pkg::BITS_W-1:0]    bits_reg, bits_next;
    logic                            mode_reg, mode_next;
    logic [kmscd_pkg::BITS_W-1:0]    events_reg, events_next;
    logic [kmscd_pkg::ROW_W-1:0]     next_row_reg, next_row_next;
    logic                            done_reg, done_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [kmscd_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [kmscd_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                            m_tlast_reg, m_tlast_next;

    logic                            ram_we, ram_re;
    logic [kmscd_pkg::BITS_W-1:0]    ram_rdata;
    logic [kmscd_pkg::BITS_W-1:0]    old_image;
    logic [kmscd_pkg::BITS_W-1:0]    diff;
    logic [kmscd_pkg::ROW_W:0]       row_inc;
    logic                            wrap;
    logic [kmscd_pkg::ROW_W-1:0]     low_idx;
    logic [kmscd_pkg::BITS_W-1:0]    events_left;
    logic                            s_accept;
    logic                            out_free;
    logic                            load_out;

    kmscd_ram #(
        .WIDTH(kmscd_pkg::BITS_W),
        .DEPTH(ROWS)
    ) u_image_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(row_reg[AW-1:0]),
        .wdata(bits_reg),
        .re   (ram_re),
        .raddr(drive_row_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign old_image = row_valid_reg[row_reg[AW-1:0]] ? ram_rdata : '0;
    assign diff      = old_image ^ bits_reg;
    assign row_inc   = {1'b0, row_reg} + 5'd1;
    assign wrap      = (row_inc >= 5'(ROWS));

    always_comb begin
        low_idx = '0;
        for (int i = kmscd_pkg::BITS_W - 1; i >= 0; i--) begin
            if (events_reg[i]) begin
                low_idx = kmscd_pkg::ROW_W'(i);
            end
        end
    end

    assign events_left = events_reg & ~(16'd1 << low_idx);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kmscd_pkg::ST_IDLE: begin
                if (s_accept && !dump_finished_reg) begin
                    state_next = kmscd_pkg::ST_LOOKUP;
                end
            end
            kmscd_pkg::ST_LOOKUP: begin
                state_next = kmscd_pkg::ST_EMIT;
            end
            kmscd_pkg::ST_EMIT: begin
                if (out_free && (events_left == '0)) begin
                    state_next = kmscd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kmscd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        s_tready           = 1'b0;
        ram_re             = 1'b0;
        ram_we             = 1'b0;
        load_out           = 1'b0;
        row_next           = row_reg;
        bits_next          = bits_reg;
        mode_next          = mode_reg;
        events_next        = events_reg;
        next_row_next      = next_row_reg;
        done_next          = done_reg;
        drive_row_next     = drive_row_reg;
        first_pass_next    = first_pass_reg;
        dump_finished_next = dump_finished_reg;
        row_valid_next     = row_valid_reg;
        unique case (state_reg)
            kmscd_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                ram_re    = s_accept;
                row_next  = drive_row_reg;
                bits_next = s_tdata[kmscd_pkg::BITS_W-1:0] & SENSE_MASK;
                mode_next = dump_mode_reg;
            end
            kmscd_pkg::ST_LOOKUP: begin
                ram_we                          = 1'b1;
                row_valid_next[row_reg[AW-1:0]] = 1'b1;
                next_row_next                   = wrap ? '0 : row_inc[kmscd_pkg::ROW_W-1:0];
                drive_row_next                  = next_row_next;
                done_next                       = mode_reg && wrap;
                events_next                     = (mode_reg || first_pass_reg) ? '0 : diff;
                if (mode_reg && wrap) begin
                    dump_finished_next = 1'b1;
                end
                if (!mode_reg && wrap) begin
                    first_pass_next = 1'b0;
                end
            end
            kmscd_pkg::ST_EMIT: begin
                load_out = out_free;
                if (out_free) begin
                    events_next = events_left;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[kmscd_pkg::SCANNED_ROW_LSB +: kmscd_pkg::ROW_W] = row_reg;
            m_tdata_next[kmscd_pkg::ROW_BITS_LSB +: kmscd_pkg::BITS_W]   = bits_reg;
            m_tdata_next[kmscd_pkg::NEXT_ROW_LSB +: kmscd_pkg::ROW_W]    = next_row_reg;
            m_tdata_next[kmscd_pkg::SCAN_DONE_BIT]                       = done_reg;
            m_tuser_next  = '0;
            m_tlast_next  = (events_left == '0);
            if (events_reg != '0) begin
                m_tdata_next[kmscd_pkg::SENSE_INDEX_LSB +: kmscd_pkg::ROW_W] = low_idx;
                m_tdata_next[kmscd_pkg::CONNECTED_BIT] = !bits_reg[low_idx];
                m_tuser_next[0] = 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= kmscd_pkg::ST_IDLE;
            dump_mode_reg     <= 1'b0;
            first_pass_reg    <= 1'b1;
            dump_finished_reg <= 1'b0;
            drive_row_reg     <= '0;
            row_valid_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            first_pass_reg    <= first_pass_next;
            dump_finished_reg <= dump_finished_next;
            drive_row_reg     <= drive_row_next;
            row_valid_reg     <= row_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                dump_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        bits_reg     <= bits_next;
        mode_reg     <= mode_next;
        events_reg   <= events_next;
        next_row_reg <= next_row_next;
        done_reg     <= done_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

`ifndef ASSERT_OFF
    a_halted_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (dump_finished_reg && (state_reg == kmscd_pkg::ST_IDLE))
            |=> (state_reg == kmscd_pkg::ST_IDLE))
        else $error("item processed after the dump pass finished");

    a_drive_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        drive_row_reg < 5'(ROWS))
        else $error("drive row beyond the line count");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[kmscd_pkg::SCAN_DONE_BIT])
            |-> (m_tlast_reg && !m_tuser_reg[0]))
        else $error("scan done on a result that is not a final dump result");

    a_lookup_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kmscd_pkg::ST_LOOKUP) |=> (state_reg == kmscd_pkg::ST_EMIT))
        else $error("lookup not followed by result emission");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the key matrix scanner with change detection.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 40;
    localparam int NUM_DIRECTED  = 22;
    localparam logic MODE_CHANGE = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  sidx;
        logic        chg;
        logic        conn;
        logic [15:0] bits;
        logic [3:0]  nxt;
        logic        done;
        logic        last;
    } scan_report_t;

    typedef struct packed {
        logic         mode;
        logic [15:0]  sense;
        logic         typed;
        scan_report_t want;
    } dir_row_t;

    localparam scan_report_t NO_REPORT = '0;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_data  = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [kmscd_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [kmscd_pkg::M_TDATA_W-1:0] m_tdata;
    logic [kmscd_pkg::M_TUSER_W-1:0] m_tuser;
    logic                            m_tlast;

    scan_report_t scan_reports[$];
    int           mismatches  = 0;
    int           items_sent  = 0;
    int           cycles      = 0;
    bit           tx_quiet    = 1'b0;
    bit           rx_quiet    = 1'b0;
    bit           hold_taken  = 1'b0;
    int           hold_left   = 0;
    int           stall_left  = 0;

    logic         mdl_dump_mode;
    logic [3:0]   mdl_drive_row;
    logic [15:0]  mdl_image [16];
    logic         mdl_first_pass;
    logic         mdl_dump_done;

    dir_row_t dir_rows [NUM_DIRECTED] = '{
        '{MODE_CHANGE, 16'hFFFF, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0, 16'hFFFF, 4'd1, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h0000, 1'b1, '{4'd1, 4'd0, 1'b0, 1'b0, 16'h0000, 4'd2, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'hAAAA, 1'b1, '{4'd2, 4'd0, 1'b0, 1'b0, 16'hAAAA, 4'd3, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h5555, 1'b1, '{4'd3, 4'd0, 1'b0, 1'b0, 16'h5555, 4'd4, 1'b0, 1'b1}},
        '{MODE_DUMP,   16'h8001, 1'b1, '{4'd4, 4'd0, 1'b0, 1'b0, 16'h8001, 4'd5, 1'b0, 1'b1}},
        '{MODE_DUMP,   16'h7FFE, 1'b1, '{4'd5, 4'd0, 1'b0, 1'b0, 16'h7FFE, 4'd6, 1'b0, 1'b1}},
        '{MODE_DUMP,   16'h0F0F, 1'b1, '{4'd6, 4'd0, 1'b0, 1'b0, 16'h0F0F, 4'd7, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h1234, 1'b1, '{4'd7, 4'd0, 1'b0, 1'b0, 16'h1234, 4'd8, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'hFFFF, 1'b1, '{4'd8, 4'd0, 1'b0, 1'b0, 16'hFFFF, 4'd9, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h0000, 1'b1, '{4'd9, 4'd0, 1'b0, 1'b0, 16'h0000, 4'd10, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'hF0F0, 1'b1, '{4'd10, 4'd0, 1'b0, 1'b0, 16'hF0F0, 4'd11, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h0001, 1'b1, '{4'd11, 4'd0, 1'b0, 1'b0, 16'h0001, 4'd12, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h8000, 1'b1, '{4'd12, 4'd0, 1'b0, 1'b0, 16'h8000, 4'd13, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'hFFFE, 1'b1, '{4'd13, 4'd0, 1'b0, 1'b0, 16'hFFFE, 4'd14, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h7FFF, 1'b1, '{4'd14, 4'd0, 1'b0, 1'b0, 16'h7FFF, 4'd15, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'hC3C3, 1'b1, '{4'd15, 4'd0, 1'b0, 1'b0, 16'hC3C3, 4'd0, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h0000, 1'b0, NO_REPORT},
        '{MODE_CHANGE, 16'hFFFF, 1'b0, NO_REPORT},
        '{MODE_CHANGE, 16'hAAAA, 1'b1, '{4'd2, 4'd0, 1'b0, 1'b0, 16'hAAAA, 4'd3, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h5554, 1'b1, '{4'd3, 4'd0, 1'b1, 1'b1, 16'h5554, 4'd4, 1'b0, 1'b1}},
        '{MODE_DUMP,   16'h8000, 1'b1, '{4'd4, 4'd0, 1'b0, 1'b0, 16'h8000, 4'd5, 1'b0, 1'b1}},
        '{MODE_CHANGE, 16'h7FFF, 1'b0, NO_REPORT}
    };

    key_matrix_scan_change_detect u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void reset_model();
        mdl_dump_mode  = MODE_CHANGE;
        mdl_drive_row  = '0;
        mdl_first_pass = 1'b1;
        mdl_dump_done  = 1'b0;
        for (int i = 0; i < 16; i++) begin
            mdl_image[i] = '0;
        end
    endfunction

    function automatic void predict_scan(input logic [15:0] sense);
        scan_report_t rep;
        logic [15:0]  diff;
        int           count;
        if (mdl_dump_done) begin
            return;
        end
        rep      = NO_REPORT;
        rep.row  = mdl_drive_row;
        rep.bits = sense;
        rep.nxt  = mdl_drive_row + 4'd1;
        if (mdl_dump_mode == MODE_DUMP) begin
            mdl_image[rep.row] = sense;
            mdl_drive_row      = rep.nxt;
            rep.done           = (rep.nxt == 4'd0);
            mdl_dump_done      = rep.done;
            rep.last           = 1'b1;
            scan_reports.push_back(rep);
            return;
        end
        diff               = mdl_image[rep.row] ^ sense;
        mdl_image[rep.row] = sense;
        count              = 0;
        if (!mdl_first_pass) begin
            for (int i = 0; i < 16; i++) begin
                if (diff[i]) begin
                    rep.sidx = 4'(i);
                    rep.chg  = 1'b1;
                    rep.conn = ~sense[i];
                    scan_reports.push_back(rep);
                    count++;
                end
            end
        end
        if (rep.nxt == 4'd0) begin
            mdl_first_pass = 1'b0;
        end
        mdl_drive_row = rep.nxt;
        if (count == 0) begin
            rep.sidx = '0;
            rep.chg  = 1'b0;
            rep.conn = 1'b0;
            scan_reports.push_back(rep);
        end
        scan_reports[$].last = 1'b1;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [15:0] pick_sense();
        logic [15:0] img;
        int          r;
        img = mdl_image[mdl_drive_row];
        r   = $urandom_range(0, 99);
        if (r < 60) begin
            repeat ($urandom_range(1, 3)) begin
                img[$urandom_range(0, 15)] ^= 1'b1;
            end
            return img;
        end else if (r < 70) begin
            return img;
        end else if (r < 80) begin
            return {16{r[0]}};
        end
        return 16'($urandom);
    endfunction

    task automatic send_scan(input logic [15:0] sense, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sense;
        do @(posedge aclk); while (!s_tready);
        predict_scan(sense);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (scan_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        mdl_dump_mode  = mode;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_taken && items_sent >= 150) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= pick_gap(1'b0);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        scan_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (scan_reports.size() == 0) begin
                $error("unexpected transaction: tdata %0h, tuser %0h, tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = scan_reports.pop_front();
                check_field("scanned_row", want.row,
                            m_tdata[kmscd_pkg::SCANNED_ROW_LSB +: kmscd_pkg::ROW_W]);
                check_field("sense_index", want.sidx,
                            m_tdata[kmscd_pkg::SENSE_INDEX_LSB +: kmscd_pkg::ROW_W]);
                check_field("change_valid", want.chg, m_tuser[0]);
                check_field("connected", want.conn, m_tdata[kmscd_pkg::CONNECTED_BIT]);
                check_field("row_bits", want.bits,
                            m_tdata[kmscd_pkg::ROW_BITS_LSB +: kmscd_pkg::BITS_W]);
                check_field("next_drive_row", want.nxt,
                            m_tdata[kmscd_pkg::NEXT_ROW_LSB +: kmscd_pkg::ROW_W]);
                check_field("scan_done", want.done, m_tdata[kmscd_pkg::SCAN_DONE_BIT]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    initial begin
        int   n;
        logic mode;
        reset_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(MODE_CHANGE);

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            if (dir_rows[k].mode != mdl_dump_mode) begin
                drain();
                write_mode(dir_rows[k].mode);
            end
            send_scan(dir_rows[k].sense, pick_gap(1'b0));
            if (dir_rows[k].typed) begin
                void'(scan_reports.pop_back());
                scan_reports.push_back(dir_rows[k].want);
            end
        end

        while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
            if (mdl_drive_row < 4'd15 && $urandom_range(0, 4) == 0) begin
                mode = MODE_DUMP;
                n    = $urandom_range(1, (15 - mdl_drive_row) < 6 ? (15 - mdl_drive_row) : 6);
            end else begin
                mode = MODE_CHANGE;
                n    = $urandom_range(8, 50);
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (mode != mdl_dump_mode) begin
                drain();
                write_mode(mode);
            end else if ($urandom_range(0, 4) == 0) begin
                drain();
            end
            repeat (n) send_scan(pick_sense(), pick_gap(tx_quiet));
        end

        drain();
        write_mode(MODE_DUMP);
        while (!mdl_dump_done) begin
            send_scan(16'($urandom), pick_gap(tx_quiet));
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (scan_reports.size() != 0) begin
            $error("%0d results never arrived", scan_reports.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ key_matrix_scan_change_detect.f @@
hw/rtl/kmscd_pkg.sv
hw/rtl/kmscd_ram.sv
hw/rtl/key_matrix_scan_change_detect.sv
bench/tb_top.sv
